[hw/rtl/assert_macros.svh]
// Assertion macros shared by the subdivider modules.
// No dependencies; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ESUB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ESUB_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ESUB_ASSERT(lbl, clk, rstn, prop)
`define ESUB_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[hw/rtl/esub_pkg.sv]
// Types, codes and default sizes of the edge midpoint subdivider.
// No dependencies; imported by every module of the block.
package esub_pkg;

    localparam int VERTEX_DEPTH_DEF = 4096;
    localparam int EDGE_SLOTS_DEF   = 8192;
    localparam int MAX_PROBES_DEF   = 8;
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int IDX_W            = 12;
    localparam int KEY_W            = 2 * IDX_W;
    localparam int FIELD_W          = 32;
    localparam int OFIFO_DEPTH      = 4;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TRI  = 2'd1;
    localparam logic [1:0] CMD_PASS = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_VFULL = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI    = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TRI,
        OP_PASS
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_E_SETUP,
        S_E_CHECK,
        S_V_RDQ,
        S_V_MID,
        S_TRI,
        S_ABORT
    } t_bstate;

    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic signed [FIELD_W-1:0] coord_z;
        logic [IDX_W-1:0]          corner_a;
        logic [IDX_W-1:0]          corner_b;
        logic [IDX_W-1:0]          corner_c;
    } t_request;

    typedef struct packed {
        logic                      kind;
        logic [IDX_W-1:0]          vertex_index;
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
        logic [IDX_W-1:0]          tri_first;
        logic [IDX_W-1:0]          tri_second;
        logic [IDX_W-1:0]          tri_third;
        logic [1:0]                status;
        logic                      last;
    } t_result;

    typedef struct packed {
        t_op      op;
        t_request req;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_f2b;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_b2f;

endpackage

[hw/rtl/esub_front.sv]
// Front end: accepts requests, classifies the command and queues jobs.
// Depends on esub_pkg and assert_macros.svh.
`include "assert_macros.svh"
module esub_front import esub_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_request i_req,
    output t_f2b     o_f2b,
    input  t_b2f     i_b2f
);
    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       keep;
    logic       wr;
    logic       rd;
    t_job       job;

    // Unused command codes are dropped here and never reach the back end.
    always_comb begin
        job.req = i_req;
        job.op  = OP_PASS;
        keep    = 1'b1;
        case (i_req.cmd)
            CMD_LOAD: job.op = OP_LOAD;
            CMD_TRI:  job.op = OP_TRI;
            CMD_PASS: job.op = OP_PASS;
            default:  keep   = 1'b0;
        endcase
    end

    assign full        = (r_cnt == 2'd2) || i_b2f.clearing;
    assign wr          = push && !full && keep;
    assign rd          = i_b2f.pop && (r_cnt != 2'd0);
    assign o_f2b.valid = (r_cnt != 2'd0);
    assign o_f2b.job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= job;
        end
    end

    `ESUB_NEVER(a_pop_empty, i_clk, i_rst_n, i_b2f.pop && !o_f2b.valid)
    `ESUB_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3)
endmodule

[hw/rtl/esub_ofifo.sv]
// Result queue between the back end and the result ports.
// Depends on esub_pkg and assert_macros.svh.
`include "assert_macros.svh"
module esub_ofifo import esub_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    empty,
    input  logic    pop,
    output t_result o_res
);
    localparam int AW = $clog2(OFIFO_DEPTH);

    t_result       r_buf [OFIFO_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          wr;
    logic          rd;

    assign o_full = (r_cnt == (AW+1)'(OFIFO_DEPTH));
    assign empty  = (r_cnt == '0);
    assign wr     = i_push && !o_full;
    assign rd     = pop && !empty;
    assign o_res  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_buf[r_wp] <= i_res;
        end
    end

    `ESUB_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full)
    `ESUB_ASSERT(a_cnt_max, i_clk, i_rst_n, r_cnt <= (AW+1)'(OFIFO_DEPTH))
endmodule

[hw/rtl/esub_back.sv]
// Back end: vertex store, edge hash table and the sequencer that runs jobs.
// Depends on esub_pkg and assert_macros.svh.
`include "assert_macros.svh"
module esub_back import esub_pkg::*; #(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
    parameter int EDGE_SLOTS   = EDGE_SLOTS_DEF,
    parameter int MAX_PROBES   = MAX_PROBES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_f2b    i_f2b,
    output t_b2f    o_b2f,
    output logic    o_push,
    output t_result o_res,
    input  logic    i_ofull
);
    localparam int VW = $clog2(VERTEX_DEPTH);
    localparam int SW = $clog2(EDGE_SLOTS);
    localparam int PW = $clog2(MAX_PROBES) + 1;
    localparam int CW = COORD_WIDTH;
    localparam int EW = KEY_W + IDX_W + 1;

    logic [3*CW-1:0] r_vmem [VERTEX_DEPTH];
    logic [EW-1:0]   r_emem [EDGE_SLOTS];
    logic [3*CW-1:0] r_vdata;
    logic [EW-1:0]   r_edata;

    t_bstate          r_state;
    t_bstate          n_state;
    t_job             r_job;
    logic [1:0]       r_k;
    logic [IDX_W-1:0] r_mid [3];
    logic [KEY_W-1:0] r_key;
    logic [SW-1:0]    r_slot;
    logic [PW-1:0]    r_probe;
    logic [3*CW-1:0]  r_pc;
    logic [1:0]       r_status;
    logic [1:0]       r_t;
    logic [VW:0]      r_count;
    logic [SW-1:0]    r_clr;

    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] q;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [18:0]      hash;
    logic [SW-1:0]    home;
    logic             p_ok;
    logic             q_ok;
    logic             vfull;
    logic             e_valid;
    logic             hit;
    logic             last_probe;
    logic [3*CW-1:0]  qc;
    logic [CW-1:0]    mx;
    logic [CW-1:0]    my;
    logic [CW-1:0]    mz;
    logic [CW:0]      sx;
    logic [CW:0]      sy;
    logic [CW:0]      sz;

    logic             pop;
    logic             ewe;
    logic [SW-1:0]    ewaddr;
    logic [EW-1:0]    ewdata;
    logic [SW-1:0]    eraddr;
    logic             vwe;
    logic [3*CW-1:0]  vwdata;
    logic [VW-1:0]    vraddr;
    logic             push;
    t_result          res;

    // Current edge: corner k to corner k+1, wrapping after the third.
    always_comb begin
        unique case (r_k)
            2'd0: begin
                p = r_job.req.corner_a;
                q = r_job.req.corner_b;
            end
            2'd1: begin
                p = r_job.req.corner_b;
                q = r_job.req.corner_c;
            end
            default: begin
                p = r_job.req.corner_c;
                q = r_job.req.corner_a;
            end
        endcase
    end

    assign lo         = (p < q) ? p : q;
    assign hi         = (p < q) ? q : p;
    assign hash       = {hi, 7'd0} ^ 19'(hi >> 5) ^ 19'(lo);
    assign home       = SW'(hash);
    assign p_ok       = 32'(p) < VERTEX_DEPTH;
    assign q_ok       = 32'(q) < VERTEX_DEPTH;
    assign vfull      = r_count >= (VW+1)'(VERTEX_DEPTH);
    assign e_valid    = r_edata[EW-1];
    assign hit        = e_valid && (r_edata[EW-2:IDX_W] == r_key);
    assign last_probe = r_probe == PW'(MAX_PROBES - 1);

    // Midpoint is floor((p + q) / 2) taken over one extra bit.
    assign qc = q_ok ? r_vdata : '0;
    assign sx = {r_pc[3*CW-1], r_pc[3*CW-1:2*CW]} + {qc[3*CW-1], qc[3*CW-1:2*CW]};
    assign sy = {r_pc[2*CW-1], r_pc[2*CW-1:CW]} + {qc[2*CW-1], qc[2*CW-1:CW]};
    assign sz = {r_pc[CW-1], r_pc[CW-1:0]} + {qc[CW-1], qc[CW-1:0]};
    assign mx = sx[CW:1];
    assign my = sy[CW:1];
    assign mz = sz[CW:1];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_f2b.valid) begin
                    unique case (i_f2b.job.op)
                        OP_LOAD: n_state = S_LOAD;
                        OP_TRI:  n_state = S_E_SETUP;
                        OP_PASS: n_state = S_CLEAR;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                if (!i_ofull) begin
                    n_state = S_IDLE;
                end
            end
            S_E_SETUP: n_state = S_E_CHECK;
            S_E_CHECK: begin
                priority if (hit) begin
                    n_state = (r_k == 2'd2) ? S_TRI : S_E_SETUP;
                end else if (e_valid) begin
                    n_state = last_probe ? S_ABORT : S_E_CHECK;
                end else begin
                    n_state = vfull ? S_ABORT : S_V_RDQ;
                end
            end
            S_V_RDQ: n_state = S_V_MID;
            S_V_MID: begin
                if (!i_ofull) begin
                    n_state = (r_k == 2'd2) ? S_TRI : S_E_SETUP;
                end
            end
            S_TRI: begin
                if (!i_ofull && r_t == 2'd3) begin
                    n_state = S_IDLE;
                end
            end
            S_ABORT: begin
                if (!i_ofull) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        pop    = 1'b0;
        ewe    = 1'b0;
        ewaddr = r_slot;
        ewdata = {1'b1, r_key, IDX_W'(r_count)};
        eraddr = r_slot;
        vwe    = 1'b0;
        vwdata = {mx, my, mz};
        vraddr = VW'(p);
        push   = 1'b0;
        res    = '0;
        unique case (r_state)
            S_CLEAR: begin
                ewe    = 1'b1;
                ewaddr = r_clr;
                ewdata = '0;
            end
            S_IDLE: pop = i_f2b.valid;
            S_LOAD: begin
                push     = !i_ofull;
                res.kind = KIND_VERTEX;
                res.last = 1'b1;
                vwdata   = {CW'(r_job.req.coord_x), CW'(r_job.req.coord_y),
                            CW'(r_job.req.coord_z)};
                if (vfull) begin
                    res.status = ST_VFULL;
                end else begin
                    vwe              = !i_ofull;
                    res.vertex_index = IDX_W'(r_count);
                    res.out_x        = FIELD_W'(vwdata[3*CW-1:2*CW]);
                    res.out_y        = FIELD_W'(vwdata[2*CW-1:CW]);
                    res.out_z        = FIELD_W'(vwdata[CW-1:0]);
                end
            end
            S_E_SETUP: eraddr = home;
            S_E_CHECK: eraddr = r_slot + 1'b1;
            S_V_RDQ:   vraddr = VW'(q);
            S_V_MID: begin
                vraddr           = VW'(q);
                push             = !i_ofull;
                vwe              = !i_ofull;
                ewe              = !i_ofull;
                res.kind         = KIND_VERTEX;
                res.vertex_index = IDX_W'(r_count);
                res.out_x        = FIELD_W'(mx);
                res.out_y        = FIELD_W'(my);
                res.out_z        = FIELD_W'(mz);
            end
            S_TRI: begin
                push     = !i_ofull;
                res.kind = KIND_TRI;
                res.last = (r_t == 2'd3);
                unique case (r_t)
                    2'd0: begin
                        res.tri_first  = r_job.req.corner_a;
                        res.tri_second = r_mid[0];
                        res.tri_third  = r_mid[2];
                    end
                    2'd1: begin
                        res.tri_first  = r_job.req.corner_b;
                        res.tri_second = r_mid[1];
                        res.tri_third  = r_mid[0];
                    end
                    2'd2: begin
                        res.tri_first  = r_job.req.corner_c;
                        res.tri_second = r_mid[2];
                        res.tri_third  = r_mid[1];
                    end
                    default: begin
                        res.tri_first  = r_mid[0];
                        res.tri_second = r_mid[1];
                        res.tri_third  = r_mid[2];
                    end
                endcase
            end
            S_ABORT: begin
                push       = !i_ofull;
                res.kind   = KIND_TRI;
                res.status = r_status;
                res.last   = 1'b1;
            end
            default: pop = 1'b0;
        endcase
    end

    assign o_push         = push;
    assign o_res          = res;
    assign o_b2f.pop      = pop;
    assign o_b2f.clearing = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (vwe) begin
            r_vmem[VW'(r_count)] <= vwdata;
        end
        r_vdata <= r_vmem[vraddr];
        if (ewe) begin
            r_emem[ewaddr] <= ewdata;
        end
        r_edata <= r_emem[eraddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if ((r_state == S_LOAD && !vfull && !i_ofull) ||
                (r_state == S_V_MID && !i_ofull)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_f2b.valid) begin
                    r_job <= i_f2b.job;
                    r_k   <= 2'd0;
                end
            end
            S_E_SETUP: begin
                r_key   <= {lo, hi};
                r_slot  <= home;
                r_probe <= '0;
            end
            S_E_CHECK: begin
                priority if (hit) begin
                    r_mid[r_k] <= r_edata[IDX_W-1:0];
                    r_k        <= r_k + 1'b1;
                    r_t        <= 2'd0;
                end else if (e_valid) begin
                    r_slot   <= r_slot + 1'b1;
                    r_probe  <= r_probe + 1'b1;
                    r_status <= ST_PROBE;
                end else begin
                    r_status <= ST_VFULL;
                end
            end
            S_V_RDQ: r_pc <= p_ok ? r_vdata : '0;
            S_V_MID: begin
                if (!i_ofull) begin
                    r_mid[r_k] <= IDX_W'(r_count);
                    r_k        <= r_k + 1'b1;
                    r_t        <= 2'd0;
                end
            end
            S_TRI: begin
                if (!i_ofull) begin
                    r_t <= r_t + 1'b1;
                end
            end
            default: r_t <= r_t;
        endcase
    end

    `ESUB_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= (VW+1)'(VERTEX_DEPTH))
    `ESUB_ASSERT(a_pass_clears, i_clk, i_rst_n, (pop && i_f2b.job.op == OP_PASS) |=> (r_state == S_CLEAR))
endmodule

[hw/rtl/edge_midpoint_subdivider.sv]
// Top level of the edge midpoint subdivider: front end, back end, result queue.
// Depends on esub_pkg, esub_front, esub_back and esub_ofifo.
//
//   channel   handshake          payload    direction
//   request   push / full        i_req      in
//   result    empty / pop        o_res      out
//
// A load is a pop, then its result. A triangle is a pop, then per edge a setup
// and a check (one more check per extra probe) plus a read and a midpoint write
// on a miss, then four triangle results. The back-end sequencer and the single
// read port of each memory set these steps. After reset and after each new-pass
// command the edge table is swept one slot a cycle; full stays high meanwhile.
// Either side may stall; the job queue and result queue absorb the slack.
module edge_midpoint_subdivider import esub_pkg::*; #(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
    parameter int EDGE_SLOTS   = EDGE_SLOTS_DEF,
    parameter int MAX_PROBES   = MAX_PROBES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_request i_req,
    output logic     empty,
    input  logic     pop,
    output t_result  o_res
);
    t_f2b    f2b;
    t_b2f    b2f;
    logic    bpush;
    t_result bres;
    logic    ofull;

    esub_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .o_f2b   (f2b),
        .i_b2f   (b2f)
    );

    esub_back #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .EDGE_SLOTS   (EDGE_SLOTS),
        .MAX_PROBES   (MAX_PROBES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_f2b   (f2b),
        .o_b2f   (b2f),
        .o_push  (bpush),
        .o_res   (bres),
        .i_ofull (ofull)
    );

    esub_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bpush),
        .i_res   (bres),
        .o_full  (ofull),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );
endmodule

[verif/edge_midpoint_subdivider_checker.sv]
// Scoreboard for the edge midpoint subdivider: watches both queue ports,
// predicts the records each accepted request causes and compares them.
// Depends on esub_pkg only.
module edge_midpoint_subdivider_checker import esub_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  logic     i_full,
    input  t_request i_req,
    input  logic     i_empty,
    input  logic     i_pop,
    input  t_result  i_res,
    output int       o_outstanding,
    output int       o_vertices,
    output int       o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVERT = VERTEX_DEPTH_DEF;
    localparam int NSLOT = EDGE_SLOTS_DEF;

    logic [FIELD_W-1:0] vert_x [NVERT];
    logic [FIELD_W-1:0] vert_y [NVERT];
    logic [FIELD_W-1:0] vert_z [NVERT];
    int unsigned        vert_count;
    logic [KEY_W-1:0]   edge_key [NSLOT];
    logic [IDX_W-1:0]   edge_vert [NSLOT];
    bit                 edge_used [NSLOT];
    t_result            awaited_records [$];
    int                 fail_count;

    assign o_outstanding = awaited_records.size();
    assign o_vertices    = vert_count;
    assign o_failures    = fail_count;

    function automatic logic [FIELD_W-1:0] halfway(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] q);
        logic [FIELD_W:0] sum;
        sum = {p[FIELD_W-1], p} + {q[FIELD_W-1], q};
        return sum[FIELD_W:1];
    endfunction

    task automatic push_vertex_record(int unsigned idx, logic [1:0] st);
        t_result rec;
        rec = '0;
        rec.kind = KIND_VERTEX;
        rec.vertex_index = idx[IDX_W-1:0];
        if (st == ST_OK) begin
            rec.out_x = vert_x[idx];
            rec.out_y = vert_y[idx];
            rec.out_z = vert_z[idx];
        end
        rec.status = st;
        rec.last = (st != ST_OK);
        awaited_records.insert(awaited_records.size(), rec);
    endtask

    task automatic push_tri_record(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                   logic [IDX_W-1:0] c, logic [1:0] st, logic fin);
        t_result rec;
        rec = '0;
        rec.kind = KIND_TRI;
        rec.tri_first = a;
        rec.tri_second = b;
        rec.tri_third = c;
        rec.status = st;
        rec.last = fin;
        awaited_records.insert(awaited_records.size(), rec);
    endtask

    // Hash lookup with bounded linear probing; a miss appends the midpoint.
    task automatic resolve_edge(input logic [IDX_W-1:0] p, input logic [IDX_W-1:0] q,
                                output logic [1:0] st, output logic [IDX_W-1:0] idx,
                                output bit added);
        logic [IDX_W-1:0] lo, hi;
        logic [KEY_W-1:0] key;
        int               home, slot;
        bit               done;
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        key = {lo, hi};
        home = ((int'(hi) << 7) ^ (int'(hi) >> 5) ^ int'(lo)) % NSLOT;
        st = ST_PROBE;
        idx = '0;
        added = 0;
        done = 0;
        for (int i = 0; i < MAX_PROBES_DEF && !done; i++) begin
            slot = (home + i) % NSLOT;
            if (edge_used[slot]) begin
                if (edge_key[slot] == key) begin
                    st = ST_OK;
                    idx = edge_vert[slot];
                    done = 1;
                end
            end else if (vert_count >= NVERT) begin
                st = ST_VFULL;
                done = 1;
            end else begin
                vert_x[vert_count] = halfway(vert_x[p], vert_x[q]);
                vert_y[vert_count] = halfway(vert_y[p], vert_y[q]);
                vert_z[vert_count] = halfway(vert_z[p], vert_z[q]);
                edge_used[slot] = 1;
                edge_key[slot] = key;
                edge_vert[slot] = vert_count[IDX_W-1:0];
                idx = vert_count[IDX_W-1:0];
                vert_count++;
                st = ST_OK;
                added = 1;
                done = 1;
            end
        end
    endtask

    task automatic subdivide_predict(t_request r);
        logic [IDX_W-1:0] corner [3];
        logic [IDX_W-1:0] mid [3];
        logic [1:0]       st;
        bit               added;
        case (r.cmd)
            CMD_LOAD: begin
                if (vert_count >= NVERT) begin
                    push_vertex_record(0, ST_VFULL);
                end else begin
                    vert_x[vert_count] = r.coord_x;
                    vert_y[vert_count] = r.coord_y;
                    vert_z[vert_count] = r.coord_z;
                    push_vertex_record(vert_count, ST_OK);
                    awaited_records[$].last = 1'b1;
                    vert_count++;
                end
            end
            CMD_TRI: begin
                corner[0] = r.corner_a;
                corner[1] = r.corner_b;
                corner[2] = r.corner_c;
                for (int k = 0; k < 3; k++) begin
                    resolve_edge(corner[k], corner[(k + 1) % 3], st, mid[k], added);
                    if (st != ST_OK) begin
                        push_tri_record('0, '0, '0, st, 1'b1);
                        return;
                    end
                    if (added)
                        push_vertex_record(mid[k], ST_OK);
                end
                push_tri_record(corner[0], mid[0], mid[2], ST_OK, 1'b0);
                push_tri_record(corner[1], mid[1], mid[0], ST_OK, 1'b0);
                push_tri_record(corner[2], mid[2], mid[1], ST_OK, 1'b0);
                push_tri_record(mid[0], mid[1], mid[2], ST_OK, 1'b1);
            end
            CMD_PASS: begin
                for (int s = 0; s < NSLOT; s++)
                    edge_used[s] = 0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic report(string field, longint unsigned want, longint unsigned got);
        $display("%0t: mismatch in %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
        fail_count++;
    endtask

    task automatic check_record(t_result got);
        t_result want;
        if (awaited_records.size() == 0) begin
            $display("%0t: unexpected record: expected none, actual 0x%0h", $time, got);
            fail_count++;
            return;
        end
        want = awaited_records.pop_front();
        if (got.kind !== want.kind) report("kind", want.kind, got.kind);
        if (got.vertex_index !== want.vertex_index)
            report("vertex_index", want.vertex_index, got.vertex_index);
        if (got.out_x !== want.out_x) report("out_x", want.out_x, got.out_x);
        if (got.out_y !== want.out_y) report("out_y", want.out_y, got.out_y);
        if (got.out_z !== want.out_z) report("out_z", want.out_z, got.out_z);
        if (got.tri_first !== want.tri_first)
            report("tri_first", want.tri_first, got.tri_first);
        if (got.tri_second !== want.tri_second)
            report("tri_second", want.tri_second, got.tri_second);
        if (got.tri_third !== want.tri_third)
            report("tri_third", want.tri_third, got.tri_third);
        if (got.status !== want.status) report("status", want.status, got.status);
        if (got.last !== want.last) report("last", want.last, got.last);
    endtask

    initial fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vert_count = 0;
            for (int s = 0; s < NSLOT; s++)
                edge_used[s] = 0;
            awaited_records.delete();
        end else begin
            if (i_push && !i_full)
                subdivide_predict(i_req);
            if (i_pop && !i_empty)
                check_record(i_res);
        end
    end
endmodule

[verif/edge_midpoint_subdivider_test.sv]
// Top of the edge midpoint subdivider testbench: clock, reset, request and
// pop stimulus and the verdict. Depends on esub_pkg and the checker module.
module edge_midpoint_subdivider_test;
    import esub_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic     i_clk;
    logic     i_rst_n;
    logic     push;
    logic     full;
    t_request i_req;
    logic     empty;
    logic     pop;
    t_result  o_res;
    int       outstanding, vertices, failures;
    int       send_idle_pct, pop_idle_pct;

    edge_midpoint_subdivider uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_req(i_req),
        .empty(empty), .pop(pop), .o_res(o_res)
    );

    edge_midpoint_subdivider_checker scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full), .i_req(i_req),
        .i_empty(empty), .i_pop(pop), .i_res(o_res),
        .o_outstanding(outstanding), .o_vertices(vertices), .o_failures(failures)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    function automatic t_request make_req(logic [1:0] cmd, int a, int b, int c);
        t_request r;
        r.cmd = cmd;
        r.coord_x = $urandom;
        r.coord_y = $urandom;
        r.coord_z = $urandom;
        r.corner_a = a[IDX_W-1:0];
        r.corner_b = b[IDX_W-1:0];
        r.corner_c = c[IDX_W-1:0];
        return r;
    endfunction

    // Prefer recent vertices so that neighboring triangles share edges.
    function automatic int pick_corner(int count);
        if (count > 16 && $urandom_range(1))
            return count - 1 - $urandom_range(15);
        return $urandom_range(count - 1);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send(t_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic drain;
        push <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    initial begin
        t_request r;
        int       sel, passes;
        push = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        send_idle_pct = 32;
        pop_idle_pct = 53;
        passes = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Coordinate extremes so that midpoints round and sign-extend at the limits.
        r = make_req(CMD_LOAD, 0, 0, 0);
        r.coord_x = 32'h7fffffff; r.coord_y = 32'h80000000; r.coord_z = 32'h0;
        send(r);
        r = make_req(CMD_LOAD, 4095, 4095, 4095);
        r.coord_x = 32'h7fffffff; r.coord_y = 32'h80000000; r.coord_z = 32'hffffffff;
        send(r);
        r = make_req(CMD_LOAD, 0, 0, 0);
        r.coord_x = 32'h80000000; r.coord_y = 32'h7fffffff; r.coord_z = 32'h1;
        send(r);
        r = make_req(CMD_LOAD, 0, 0, 0);
        r.coord_x = 32'hffffffff; r.coord_y = 32'h00000001; r.coord_z = 32'h80000000;
        send(r);
        send(make_req(CMD_LOAD, 0, 0, 0));
        send(make_req(CMD_TRI, 0, 1, 2));
        send(make_req(CMD_TRI, 0, 1, 2));
        send(make_req(CMD_TRI, 2, 1, 3));
        send(make_req(CMD_TRI, 4, 4, 4));
        send(make_req(CMD_TRI, 0, 0, 1));
        send(make_req(CMD_UNUSED, 1, 2, 3));
        send(make_req(CMD_PASS, 0, 0, 0));
        send(make_req(CMD_TRI, 2, 0, 1));
        send(make_req(CMD_TRI, 3, 3, 2));

        for (int n = 0; n < 330; n++) begin
            if (n == 165) begin
                send_idle_pct = 53;
                pop_idle_pct = 32;
            end
            sel = $urandom_range(99);
            if (sel < 44)
                r = make_req(CMD_LOAD, $urandom, $urandom, $urandom);
            else if (sel < 97 || (sel >= 98 && passes >= 3))
                r = make_req(CMD_TRI, pick_corner(vertices), pick_corner(vertices),
                             pick_corner(vertices));
            else if (sel == 97)
                r = make_req(CMD_UNUSED, $urandom, $urandom, $urandom);
            else begin
                r = make_req(CMD_PASS, $urandom, $urandom, $urandom);
                passes++;
            end
            send(r);
        end

        send_idle_pct = 0;
        pop_idle_pct = 0;
        while (vertices < 128)
            send(make_req(CMD_LOAD, $urandom, $urandom, $urandom));
        send(make_req(CMD_PASS, 0, 0, 0));
        // Edges (m, 40) for m below ten fill the run of slots that starts at
        // 40 * 128. The edge (3, 104) has its home at the start of that run,
        // so it runs out of probes, once alone and once after a midpoint.
        for (int m = 0; m < 10; m++)
            send(make_req(CMD_TRI, m, 40, 40));
        send(make_req(CMD_TRI, 3, 104, 104));
        send(make_req(CMD_TRI, 104, 104, 3));

        drain();
        repeat (40) @(posedge i_clk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
